[rtl/cmr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmr_pkg
// Shared types, codes and helpers of the CAN multipart reassembler.
// ----------------------------------------------------------------------------
package cmr_pkg;

    localparam int SLOT_COUNT_DEF  = 4;
    localparam int MAX_PAYLOAD_DEF = 64;
    localparam int CFG_IDX_W       = 2;

    localparam logic [7:0] FIRST_SEQ = 8'h00;
    localparam logic [3:0] FIRST_HDR = 4'd2;
    localparam logic [3:0] NEXT_HDR  = 4'd1;

    localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_INIT = 2'd1;

    localparam logic [7:0] CRC_POLY_RST = 8'd7;
    localparam logic [7:0] CRC_INIT_RST = 8'd0;

    localparam logic [3:0] ST_DELIVERED = 4'd0;
    localparam logic [3:0] ST_STORED    = 4'd1;
    localparam logic [3:0] ST_EXTENDED  = 4'd2;
    localparam logic [3:0] ST_REMOTE    = 4'd3;
    localparam logic [3:0] ST_EMPTY     = 4'd4;
    localparam logic [3:0] ST_NOSLOT    = 4'd5;
    localparam logic [3:0] ST_TOOLONG   = 4'd6;
    localparam logic [3:0] ST_SEQERR    = 4'd7;
    localparam logic [3:0] ST_CRCERR    = 4'd8;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_SINGLE = 2'd1;
    localparam logic [1:0] KIND_STORE  = 2'd2;

    typedef struct packed {
        logic        is_extended;
        logic        is_remote;
        logic [3:0]  source_node;
        logic [3:0]  target_node;
        logic        is_multipart;
        logic [3:0]  byte_count;
        logic [63:0] frame_data;
    } frame_t;

    typedef struct packed {
        logic [3:0] status;
        logic [3:0] msg_source;
        logic [3:0] msg_target;
        logic [6:0] msg_length;
        logic [5:0] byte_position;
        logic [7:0] byte_value;
        logic       last;
    } result_t;

    typedef struct packed {
        logic capture;
        logic decode;
        logic write;
        logic crc_run;
        logic check;
        logic deliver_run;
        logic single_run;
    } cmr_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       write_done;
        logic       lastframe;
        logic       crc_done;
        logic       crc_ok;
        logic       len_zero;
        logic       deliver_done;
        logic       single_done;
    } cmr_stat_t;

    // One byte of an MSB-first CRC-8.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ poly;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[rtl/cmr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/cmr_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmr_datapath
// Frame decode, slot table, payload memory, CRC unit and result register.
// ----------------------------------------------------------------------------
module cmr_datapath #(
    parameter int SLOT_COUNT  = cmr_pkg::SLOT_COUNT_DEF,
    parameter int MAX_PAYLOAD = cmr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cmr_pkg::frame_t                    frame,
    input  logic                               cfg_valid,
    input  logic [cmr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [7:0]                         cfg_data,
    input  cmr_pkg::cmr_cmd_t                  cmd,
    output cmr_pkg::cmr_stat_t                 stat,
    output logic                               result_valid,
    output cmr_pkg::result_t                   result
);
    import cmr_pkg::*;

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int PW = $clog2(MAX_PAYLOAD);
    localparam int LW = $clog2(MAX_PAYLOAD + 1);
    localparam int DEPTH = SLOT_COUNT * MAX_PAYLOAD;
    localparam int AW = $clog2(DEPTH);

    logic [7:0] poly_reg, init_reg;
    frame_t     frame_reg;

    logic [SLOT_COUNT-1:0] slot_busy_reg;
    logic [3:0]            slot_source_reg [SLOT_COUNT];
    logic [7:0]            slot_exp_reg    [SLOT_COUNT];
    logic [7:0]            slot_filled_reg [SLOT_COUNT];
    logic [7:0]            slot_seq_reg    [SLOT_COUNT];

    logic [SW-1:0]  slot_reg;
    logic [7:0]     wr_pos_reg;
    logic [3:0]     copy_reg;
    logic [3:0]     offset_reg;
    logic [2:0]     crc_idx_reg;
    logic           lastframe_reg;
    logic [LW-1:0]  len_reg;
    logic [7:0]     crc_reg;
    logic [LW-1:0]  rd_cnt_reg;
    logic [LW-1:0]  acc_cnt_reg;
    logic           pend_reg;
    logic           result_valid_reg;
    result_t        result_reg;

    // decode
    logic [3:0]    dlc;
    logic [7:0]    d0, d1;
    logic          first;
    logic          hit, free;
    logic [SW-1:0] hit_idx, free_idx, sel_idx;
    logic          found;
    logic [1:0]    dec_kind;
    logic [3:0]    dec_code;
    logic [7:0]    exp_cur, fill_cur, remaining;
    logic [3:0]    offset, avail, copy;
    logic          lastframe;

    assign dlc   = (frame_reg.byte_count > 4'd8) ? 4'd8 : frame_reg.byte_count;
    assign d0    = frame_reg.frame_data[7:0];
    assign d1    = frame_reg.frame_data[15:8];
    assign first = (d0 == FIRST_SEQ);

    always_comb
    begin
        hit      = 1'b0;
        free     = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int s = SLOT_COUNT - 1; s >= 0; s--)
        begin
            if (slot_busy_reg[s] && slot_source_reg[s] == frame_reg.source_node)
            begin
                hit     = 1'b1;
                hit_idx = SW'(s);
            end
            if (!slot_busy_reg[s])
            begin
                free     = 1'b1;
                free_idx = SW'(s);
            end
        end
    end

    assign sel_idx  = hit ? hit_idx : free_idx;
    assign found    = hit || (first && free);
    assign exp_cur  = first ? d1 : slot_exp_reg[sel_idx];
    assign fill_cur = first ? 8'd0 : slot_filled_reg[sel_idx];
    assign offset   = first ? FIRST_HDR : NEXT_HDR;
    assign avail    = dlc - offset;
    assign remaining = (fill_cur <= exp_cur) ? (exp_cur - fill_cur) : 8'd0;

    always_comb
    begin
        if (remaining >= {4'd0, avail})
        begin
            copy      = avail;
            lastframe = 1'b0;
        end
        else if (remaining + 8'd1 == {4'd0, avail})
        begin
            copy      = avail - 4'd1;
            lastframe = 1'b1;
        end
        else
        begin
            copy      = remaining[3:0];
            lastframe = 1'b1;
        end
    end

    always_comb
    begin
        dec_kind = KIND_STATUS;
        dec_code = ST_STORED;
        if (frame_reg.is_extended)
            dec_code = ST_EXTENDED;
        else if (frame_reg.is_remote)
            dec_code = ST_REMOTE;
        else if (!frame_reg.is_multipart)
            dec_kind = KIND_SINGLE;
        else if (dlc < FIRST_HDR)
            dec_code = ST_EMPTY;
        else if (!found)
            dec_code = ST_NOSLOT;
        else if (first && d1 > 8'(MAX_PAYLOAD))
            dec_code = ST_TOOLONG;
        else if (!first && slot_seq_reg[sel_idx] != d0)
            dec_code = ST_SEQERR;
        else
            dec_kind = KIND_STORE;
    end

    // memory
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr, slot_base;
    logic [7:0]    ram_wdata, ram_rdata;
    logic [7:0]    wpos;
    logic          write_done;

    assign slot_base  = AW'(slot_reg * MAX_PAYLOAD);
    assign write_done = (acc_cnt_reg == LW'(copy_reg));
    assign wpos       = wr_pos_reg + 8'(acc_cnt_reg);
    assign ram_we     = cmd.write && !write_done;
    assign ram_waddr  = slot_base + AW'(wpos[PW-1:0]);
    assign ram_wdata  = frame_reg.frame_data[3'(offset_reg + 4'(acc_cnt_reg)) * 8 +: 8];
    assign ram_raddr  = slot_base + AW'(rd_cnt_reg[PW-1:0]);

    cmr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic reading;
    logic crc_ok;
    logic single_done;
    assign reading     = (cmd.crc_run || cmd.deliver_run) && (rd_cnt_reg < len_reg);
    assign crc_ok      = (crc_reg == frame_reg.frame_data[crc_idx_reg * 8 +: 8]);
    assign single_done = (dlc == 4'd0) || (acc_cnt_reg + LW'(1) == LW'(dlc));

    assign stat.kind         = dec_kind;
    assign stat.write_done   = write_done;
    assign stat.lastframe    = lastframe_reg;
    assign stat.crc_done     = (acc_cnt_reg == len_reg);
    assign stat.crc_ok       = crc_ok;
    assign stat.len_zero     = (len_reg == '0);
    assign stat.deliver_done = (acc_cnt_reg == len_reg);
    assign stat.single_done  = single_done;

    // results
    logic    res_valid_next;
    result_t res_next;

    always_comb
    begin
        res_valid_next = 1'b0;
        res_next       = '0;
        res_next.last  = 1'b1;
        if (cmd.decode && dec_kind == KIND_STATUS)
        begin
            res_valid_next  = 1'b1;
            res_next.status = dec_code;
        end
        else if (cmd.write && write_done && !lastframe_reg)
        begin
            res_valid_next  = 1'b1;
            res_next.status = ST_STORED;
        end
        else if (cmd.check && !crc_ok)
        begin
            res_valid_next  = 1'b1;
            res_next.status = ST_CRCERR;
        end
        else if ((cmd.check && len_reg == '0) || (cmd.single_run && dlc == 4'd0))
        begin
            // empty delivery
            res_valid_next      = 1'b1;
            res_next.status     = ST_DELIVERED;
            res_next.msg_source = frame_reg.source_node;
            res_next.msg_target = frame_reg.target_node;
        end
        else if (cmd.deliver_run && pend_reg)
        begin
            res_valid_next         = 1'b1;
            res_next.status        = ST_DELIVERED;
            res_next.msg_source    = frame_reg.source_node;
            res_next.msg_target    = frame_reg.target_node;
            res_next.msg_length    = 7'(len_reg);
            res_next.byte_position = 6'(acc_cnt_reg);
            res_next.byte_value    = ram_rdata;
            res_next.last          = (acc_cnt_reg + LW'(1) == len_reg);
        end
        else if (cmd.single_run)
        begin
            res_valid_next         = 1'b1;
            res_next.status        = ST_DELIVERED;
            res_next.msg_source    = frame_reg.source_node;
            res_next.msg_target    = frame_reg.target_node;
            res_next.msg_length    = 7'(dlc);
            res_next.byte_position = 6'(acc_cnt_reg);
            res_next.byte_value    = frame_reg.frame_data[acc_cnt_reg[2:0] * 8 +: 8];
            res_next.last          = single_done;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            frame_reg <= frame;
        if (res_valid_next)
            result_reg <= res_next;
        if (cmd.decode)
        begin
            slot_reg      <= sel_idx;
            wr_pos_reg    <= fill_cur;
            copy_reg      <= copy;
            offset_reg    <= offset;
            crc_idx_reg   <= 3'(offset + copy);
            lastframe_reg <= lastframe;
            len_reg       <= LW'(exp_cur);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg         <= CRC_POLY_RST;
            init_reg         <= CRC_INIT_RST;
            slot_busy_reg    <= '0;
            crc_reg          <= '0;
            rd_cnt_reg       <= '0;
            acc_cnt_reg      <= '0;
            pend_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            for (int s = 0; s < SLOT_COUNT; s++)
            begin
                slot_source_reg[s] <= '0;
                slot_exp_reg[s]    <= '0;
                slot_filled_reg[s] <= '0;
                slot_seq_reg[s]    <= '0;
            end
        end
        else
        begin
            result_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_index == REG_CRC_POLY)
                poly_reg <= cfg_data;
            if (cfg_valid && cfg_index == REG_CRC_INIT)
                init_reg <= cfg_data;

            if (cmd.decode)
            begin
                crc_reg     <= init_reg;
                rd_cnt_reg  <= '0;
                acc_cnt_reg <= '0;
                pend_reg    <= 1'b0;
                if (frame_reg.is_multipart && !frame_reg.is_extended
                    && !frame_reg.is_remote && dlc >= FIRST_HDR && found)
                begin
                    if (dec_kind == KIND_STORE)
                    begin
                        slot_source_reg[sel_idx] <= frame_reg.source_node;
                        slot_exp_reg[sel_idx]    <= exp_cur;
                        slot_filled_reg[sel_idx] <= fill_cur + 8'(copy);
                        slot_seq_reg[sel_idx]    <= first ? 8'd1 : slot_seq_reg[sel_idx] + 8'd1;
                        slot_busy_reg[sel_idx]   <= !lastframe;
                    end
                    else if (dec_code == ST_SEQERR)
                    begin
                        slot_busy_reg[sel_idx] <= 1'b0;
                    end
                end
            end
            else if (cmd.write)
            begin
                // count the written bytes; restart the counter for the read passes when done
                if (write_done)
                    acc_cnt_reg <= '0;
                else
                    acc_cnt_reg <= acc_cnt_reg + LW'(1);
            end
            else if (cmd.check)
            begin
                rd_cnt_reg  <= '0;
                acc_cnt_reg <= '0;
                pend_reg    <= 1'b0;
            end
            else if (cmd.crc_run || cmd.deliver_run)
            begin
                pend_reg <= reading;
                if (reading)
                    rd_cnt_reg <= rd_cnt_reg + LW'(1);
                if (pend_reg)
                begin
                    acc_cnt_reg <= acc_cnt_reg + LW'(1);
                    if (cmd.crc_run)
                        crc_reg <= crc8_step(crc_reg, ram_rdata, poly_reg);
                end
            end
            else if (cmd.single_run)
            begin
                acc_cnt_reg <= acc_cnt_reg + LW'(1);
            end
        end
    end
endmodule

[rtl/cmr_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmr_controller
// Sequencer: capture, decode, payload write, CRC pass, check, delivery pass, single-frame delivery.
// ----------------------------------------------------------------------------
module cmr_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  cmr_pkg::cmr_stat_t stat,
    output cmr_pkg::cmr_cmd_t  cmd
);
    import cmr_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECODE  = 3'd1;
    localparam logic [2:0] S_WRITE   = 3'd2;
    localparam logic [2:0] S_CRC     = 3'd3;
    localparam logic [2:0] S_CHECK   = 3'd4;
    localparam logic [2:0] S_DELIVER = 3'd5;
    localparam logic [2:0] S_SINGLE  = 3'd6;

    logic [2:0] state_reg, state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.capture = start;
                if (start)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                case (stat.kind)
                    KIND_SINGLE: state_next = S_SINGLE;
                    KIND_STORE:  state_next = S_WRITE;
                    default:     state_next = S_IDLE;
                endcase
            end
            S_WRITE:
            begin
                cmd.write = 1'b1;
                if (stat.write_done)
                    state_next = stat.lastframe ? S_CRC : S_IDLE;
            end
            S_CRC:
            begin
                cmd.crc_run = 1'b1;
                if (stat.crc_done)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                if (stat.crc_ok && !stat.len_zero)
                    state_next = S_DELIVER;
                else
                    state_next = S_IDLE;
            end
            S_DELIVER:
            begin
                cmd.deliver_run = 1'b1;
                if (stat.deliver_done)
                    state_next = S_IDLE;
            end
            S_SINGLE:
            begin
                cmd.single_run = 1'b1;
                if (stat.single_done)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

[rtl/can_multipart_reassembler_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_multipart_reassembler_core
// Reassembles multipart CAN messages per source node and streams them out.
// ----------------------------------------------------------------------------
// channel   dir  handshake             word
// frame     in   start & !busy         frame_t
// result    out  result_valid strobe   result_t
// cfg       in   cfg_valid & cfg_ready cfg_index, cfg_data
//
// A rejected frame is captured and decoded; a stored one then writes its copied bytes.
// A plain frame is streamed out byte by byte from the frame register.
// A completing frame also runs a CRC pass and a check, then the delivery pass;
// a CRC error or a length of 0 ends it after the check.
// The payload RAM port reads one byte a cycle for the CRC pass and delivery.
// Reset clears the slot table; payload RAM needs no clearing.
// Results are single-cycle strobes; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module can_multipart_reassembler_core #(
    parameter int SLOT_COUNT  = cmr_pkg::SLOT_COUNT_DEF,
    parameter int MAX_PAYLOAD = cmr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  cmr_pkg::frame_t               frame,
    output logic                          result_valid,
    output cmr_pkg::result_t              result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cmr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data
);
    import cmr_pkg::*;

    cmr_cmd_t  cmd;
    cmr_stat_t stat;

    assign cfg_ready = 1'b1;

    cmr_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    cmr_datapath #(
        .SLOT_COUNT  (SLOT_COUNT),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame        (frame),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );
endmodule
